// ===== rtl/phase_congruency_moments_defines.svh =====
// Assertion macros for the phase congruency moment block.
// Used by rtl/phase_congruency_moments.sv; needs clk_i and rst_ni in scope.
`ifndef PHASE_CONGRUENCY_MOMENTS_DEFINES_SVH
`define PHASE_CONGRUENCY_MOMENTS_DEFINES_SVH
`ifndef SYNTH
`define PCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PCM_ASSERT_IMP(lbl, ante, cons) \
  `PCM_ASSERT(lbl, (ante) |-> (cons))
`else
`define PCM_ASSERT(lbl, prop)
`define PCM_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/pcm_pkg.sv =====
// Package for the phase congruency moment block: widths, trig and 1/N tables.
// No dependencies.
package pcm_pkg;

  localparam int unsigned NumOrient = 8;
  localparam int unsigned PcW       = 16;
  localparam int unsigned CntW      = 4;
  localparam int unsigned OIdxW     = 3;
  localparam int unsigned CoefW     = 18;
  localparam int unsigned RadW      = 44;
  localparam int unsigned RootW     = 22;
  localparam int unsigned SumW      = 22;
  localparam int unsigned SqrtStages = RadW / 2;
  // input accept to result strobe, in cycles
  localparam int unsigned PipeLat   = 8 + SqrtStages;

  localparam logic [CntW-1:0] CntReset = 4'd6;

  // cos/sin of o*pi/N in signed Q16, row N-1, column o
  localparam logic signed [CoefW-1:0] CosTab [NumOrient][NumOrient] = '{
    '{18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd65536, 18'sd32768, -18'sd32768, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd65536, 18'sd46341, 18'sd0, -18'sd46341, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd65536, 18'sd53020, 18'sd20252, -18'sd20252, -18'sd53020,
      18'sd0, 18'sd0, 18'sd0},
    '{18'sd65536, 18'sd56756, 18'sd32768, 18'sd0, -18'sd32768, -18'sd56756,
      18'sd0, 18'sd0},
    '{18'sd65536, 18'sd59046, 18'sd40861, 18'sd14583, -18'sd14583, -18'sd40861,
      -18'sd59046, 18'sd0},
    '{18'sd65536, 18'sd60547, 18'sd46341, 18'sd25080, 18'sd0, -18'sd25080,
      -18'sd46341, -18'sd60547}
  };

  localparam logic signed [CoefW-1:0] SinTab [NumOrient][NumOrient] = '{
    '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd0, 18'sd56756, 18'sd56756, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd0, 18'sd46341, 18'sd65536, 18'sd46341, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd0, 18'sd38521, 18'sd62328, 18'sd62328, 18'sd38521, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd0, 18'sd32768, 18'sd56756, 18'sd65536, 18'sd56756, 18'sd32768,
      18'sd0, 18'sd0},
    '{18'sd0, 18'sd28435, 18'sd51238, 18'sd63893, 18'sd63893, 18'sd51238,
      18'sd28435, 18'sd0},
    '{18'sd0, 18'sd25080, 18'sd46341, 18'sd60547, 18'sd65536, 18'sd60547,
      18'sd46341, 18'sd25080}
  };

  // round(2^16 / N), index N-1
  localparam logic [16:0] RecipTab [NumOrient] = '{
    17'd65536, 17'd32768, 17'd21845, 17'd16384,
    17'd13107, 17'd10923, 17'd9362, 17'd8192
  };

endpackage

// ===== rtl/pcm_lane.sv =====
// One orientation lane: weights pc by cos/sin, forms rounded x*x, y*y, x*y.
// Depends on pcm_pkg. Two register stages.
module pcm_lane import pcm_pkg::*; (
  input  logic                    clk_i,
  input  logic [PcW-1:0]          pc_i,
  input  logic signed [CoefW-1:0] cos_i,
  input  logic signed [CoefW-1:0] sin_i,
  output logic [15:0]             x2_o,
  output logic [15:0]             y2_o,
  output logic signed [16:0]      xy_o
);

  logic [16:0] cmag, smag;
  logic [32:0] xprod, yprod;
  logic [15:0] xmag_d, ymag_d, xmag_q, ymag_q;
  logic        xneg_q, yneg_q;
  logic [31:0] xx, yy, xy;
  logic [15:0] xym;

  // stage A: x = pc*cos, y = pc*sin, rounded half away from zero
  always_comb begin
    cmag   = cos_i[CoefW-1] ? 17'(-cos_i) : cos_i[16:0];
    smag   = sin_i[CoefW-1] ? 17'(-sin_i) : sin_i[16:0];
    xprod  = ({17'd0, pc_i} * {16'd0, cmag}) + 33'd32768;
    yprod  = ({17'd0, pc_i} * {16'd0, smag}) + 33'd32768;
    xmag_d = xprod[31:16];
    ymag_d = yprod[31:16];
  end

  always_ff @(posedge clk_i) begin
    xmag_q <= xmag_d;
    ymag_q <= ymag_d;
    xneg_q <= cos_i[CoefW-1];
    yneg_q <= sin_i[CoefW-1];
  end

  // stage B: products rounded to Q16
  always_comb begin
    xx  = 32'(xmag_q * xmag_q) + 32'd32768;
    yy  = 32'(ymag_q * ymag_q) + 32'd32768;
    xy  = 32'(xmag_q * ymag_q) + 32'd32768;
    xym = xy[31:16];
  end

  always_ff @(posedge clk_i) begin
    x2_o <= xx[31:16];
    y2_o <= yy[31:16];
    xy_o <= (xneg_q ^ yneg_q) ? -$signed({1'b0, xym}) : $signed({1'b0, xym});
  end

endmodule

// ===== rtl/pcm_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband sum.
// Depends on pcm_pkg.
module pcm_isqrt import pcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [SumW-1:0]  sum_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [SumW-1:0]  sum_o
);

  logic [RootW:0]   rem_q  [SqrtStages];
  logic [RootW-1:0] root_q [SqrtStages];
  logic [RadW-1:0]  rad_q  [SqrtStages];
  logic [SumW-1:0]  sum_q  [SqrtStages];
  logic [SqrtStages-1:0] vld_q;

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [RootW:0]   rem_in, rem_d;
    logic [RootW-1:0] root_in, root_d;
    logic [RadW-1:0]  rad_in;
    logic [SumW-1:0]  sum_in;
    logic             vld_in;
    logic [RootW+2:0] r2, t;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sum_in  = sum_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sum_in  = sum_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // trial subtract of (root<<2)|1
    always_comb begin
      r2 = {rem_in, rad_in[RadW-1 -: 2]};
      t  = {1'b0, root_in, 2'b01};
      if (r2 >= t) begin
        rem_d  = (RootW+1)'(r2 - t);
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = r2[RootW:0];
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
      sum_q[k]  <= sum_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign sum_o   = sum_q[SqrtStages-1];

endmodule

// ===== rtl/phase_congruency_moments.sv =====
// Phase congruency moments: eight orientation lanes, merge, scale, root, output.
// Result strobe valid_o comes from the output register after the square root pipeline.
// Throughput: one item per cycle; busy is never raised and results cannot stall.
// The 22-stage square root pipeline sets most of the latency.
// Reset (rst_ni low, async): pipeline empties, orientation count cnt_q returns to 6.
`include "phase_congruency_moments_defines.svh"
module phase_congruency_moments import pcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [PcW-1:0]   pc_orient_0_i,
  input  logic [PcW-1:0]   pc_orient_1_i,
  input  logic [PcW-1:0]   pc_orient_2_i,
  input  logic [PcW-1:0]   pc_orient_3_i,
  input  logic [PcW-1:0]   pc_orient_4_i,
  input  logic [PcW-1:0]   pc_orient_5_i,
  input  logic [PcW-1:0]   pc_orient_6_i,
  input  logic [PcW-1:0]   pc_orient_7_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CntW-1:0]  cfg_data_i,
  output logic             valid_o,
  output logic [7:0]       edge_strength_o,
  output logic [7:0]       corner_strength_o
);

  logic [CntW-1:0]  cnt_q;
  logic [OIdxW-1:0] nidx;
  logic [PcW-1:0]   pc [NumOrient];
  logic [15:0]      x2 [NumOrient];
  logic [15:0]      y2 [NumOrient];
  logic signed [16:0] xy [NumOrient];
  logic             accept;
  logic [6:0]       vld_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // orientation count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_q <= cfg_data_i;
    end
  end

  // zero means one, above eight means eight
  always_comb begin
    if (cnt_q == '0) begin
      nidx = '0;
    end else if (cnt_q > CntW'(NumOrient)) begin
      nidx = OIdxW'(NumOrient - 1);
    end else begin
      nidx = OIdxW'(cnt_q - 4'd1);
    end
  end

  assign pc[0] = pc_orient_0_i;
  assign pc[1] = pc_orient_1_i;
  assign pc[2] = pc_orient_2_i;
  assign pc[3] = pc_orient_3_i;
  assign pc[4] = pc_orient_4_i;
  assign pc[5] = pc_orient_5_i;
  assign pc[6] = pc_orient_6_i;
  assign pc[7] = pc_orient_7_i;

  // lanes; unused orientations get zero coefficients from the tables
  for (genvar o = 0; o < NumOrient; o++) begin : g_lane
    pcm_lane u_lane (
      .clk_i (clk_i),
      .pc_i  (pc[o]),
      .cos_i (CosTab[nidx][o]),
      .sin_i (SinTab[nidx][o]),
      .x2_o  (x2[o]),
      .y2_o  (y2[o]),
      .xy_o  (xy[o])
    );
  end

  // valid pipe: lane A, lane B, merge, scale, diff, square, add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], accept};
    end
  end

  // merge: sum lane results
  logic [18:0]        sx2_d, sy2_d, sx2_q, sy2_q;
  logic signed [19:0] sxy_d, sxy_q;

  always_comb begin
    sx2_d = '0;
    sy2_d = '0;
    sxy_d = '0;
    for (int o = 0; o < NumOrient; o++) begin
      sx2_d = sx2_d + 19'(x2[o]);
      sy2_d = sy2_d + 19'(y2[o]);
      sxy_d = sxy_d + 20'(xy[o]);
    end
  end

  always_ff @(posedge clk_i) begin
    sx2_q <= sx2_d;
    sy2_q <= sy2_d;
    sxy_q <= sxy_d;
  end

  // scale by 2/N, 2/N, 4/N with rounding
  logic [16:0] recip;
  logic [18:0] sxym;
  logic [36:0] px2, py2;
  logic [37:0] pxy;
  logic [20:0] cx2_q, cy2_q, cxy_q;

  always_comb begin
    recip = RecipTab[nidx];
    sxym  = sxy_q[19] ? 19'(-sxy_q) : sxy_q[18:0];
    px2   = (sx2_q * {recip, 1'b0}) + 37'd32768;
    py2   = (sy2_q * {recip, 1'b0}) + 37'd32768;
    pxy   = (sxym * {recip, 2'b00}) + 38'd32768;
  end

  always_ff @(posedge clk_i) begin
    cx2_q <= px2[36:16];
    cy2_q <= py2[36:16];
    cxy_q <= pxy[36:16];
  end

  // difference magnitude and sum
  logic [20:0]     dmag_q, cmag_q;
  logic [SumW-1:0] sum_e_q, sum_f_q, sum_g_q;

  always_ff @(posedge clk_i) begin
    dmag_q  <= (cx2_q >= cy2_q) ? (cx2_q - cy2_q) : (cy2_q - cx2_q);
    cmag_q  <= cxy_q;
    sum_e_q <= SumW'(cx2_q) + SumW'(cy2_q);
  end

  // squares, then radicand
  logic [41:0]     dsq_q, csq_q;
  logic [RadW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    dsq_q   <= dmag_q * dmag_q;
    csq_q   <= cmag_q * cmag_q;
    sum_f_q <= sum_e_q;
    rad_q   <= RadW'(dsq_q) + RadW'(csq_q);
    sum_g_q <= sum_f_q;
  end

  logic             sq_vld;
  logic [RootW-1:0] root;
  logic [SumW-1:0]  sum_s;

  pcm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[6]),
    .rad_i   (rad_q),
    .sum_i   (sum_g_q),
    .valid_o (sq_vld),
    .root_o  (root),
    .sum_o   (sum_s)
  );

  // moment*255 rounded, saturated to a byte
  function automatic logic [7:0] to_byte(input logic signed [23:0] m2);
    logic [31:0] v;
    begin
      v = 32'(m2[22:0]) * 32'd255 + 32'd65536;
      if (m2 <= 0) begin
        to_byte = 8'd0;
      end else if (v[31:17] > 15'd255) begin
        to_byte = 8'd255;
      end else begin
        to_byte = v[24:17];
      end
    end
  endfunction

  logic signed [23:0] mmax, mmin;

  always_comb begin
    mmax = $signed({2'b00, sum_s}) + $signed({2'b00, root});
    mmin = $signed({2'b00, sum_s}) - $signed({2'b00, root});
  end

  always_ff @(posedge clk_i) begin
    edge_strength_o   <= to_byte(mmax);
    corner_strength_o <= to_byte(mmin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= sq_vld;
    end
  end

  `PCM_ASSERT_IMP(a_min_le_max, valid_o, corner_strength_o <= edge_strength_o)
  `PCM_ASSERT_IMP(a_latency, accept, ##PipeLat valid_o)
  `PCM_ASSERT(a_no_spurious, valid_o |-> $past(accept, PipeLat))

endmodule
